// File: hw/rtl/vssd_pkg.sv
// shared types, base codes and site rules for the variant-site snp distance block
// no dependencies; imported by vssd_model_mem and variant_site_snp_distance
package vssd_pkg;

	typedef logic [7:0] base_t;

	localparam int COUNT_W = 24;
	typedef logic [COUNT_W-1:0] count_t;

	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

	// request kinds
	localparam logic MODE_MERGE   = 1'b0;
	localparam logic MODE_COMPARE = 1'b1;

	// site and base codes
	localparam base_t UNSET_SITE   = 8'h09;
	localparam base_t VARIANT_SITE = 8'h2E;
	localparam base_t BASE_N       = 8'h4E;
	localparam base_t BASE_GAP     = 8'h2D;
	localparam base_t BASE_QUERY   = 8'h3F;
	localparam base_t BASE_UPPER_A = 8'h41;
	localparam base_t BASE_UPPER_C = 8'h43;
	localparam base_t BASE_UPPER_G = 8'h47;
	localparam base_t BASE_UPPER_T = 8'h54;
	localparam base_t BASE_UPPER_U = 8'h55;
	localparam base_t BASE_LOWER_A = 8'h61;
	localparam base_t BASE_LOWER_C = 8'h63;
	localparam base_t BASE_LOWER_G = 8'h67;
	localparam base_t BASE_LOWER_T = 8'h74;
	localparam base_t BASE_LOWER_U = 8'h75;

	// whitespace codes
	localparam base_t CHR_SPACE = 8'h20;
	localparam base_t CHR_TAB   = 8'h09;
	localparam base_t CHR_CR    = 8'h0D;
	localparam base_t CHR_LF    = 8'h0A;
	localparam base_t CHR_VT    = 8'h0B;
	localparam base_t CHR_BS    = 8'h08;
	localparam base_t CHR_FF    = 8'h0C;

	function automatic logic is_gap_or_n(input base_t c);
		return (c == BASE_N) || (c == BASE_GAP);
	endfunction

	function automatic logic is_masked(input base_t c);
		return is_gap_or_n(c) || (c == BASE_QUERY);
	endfunction

	function automatic logic is_blank(input base_t c);
		return c inside {CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF, CHR_VT, CHR_BS, CHR_FF};
	endfunction

	// lowercase acgt to upper case, u/U to T
	function automatic base_t fold_base(input base_t c);
		base_t f;
		case (c)
			BASE_LOWER_A: f = BASE_UPPER_A;
			BASE_LOWER_C: f = BASE_UPPER_C;
			BASE_LOWER_G: f = BASE_UPPER_G;
			BASE_LOWER_T: f = BASE_UPPER_T;
			BASE_UPPER_U: f = BASE_UPPER_T;
			BASE_LOWER_U: f = BASE_UPPER_T;
			default:      f = c;
		endcase
		return f;
	endfunction

	function automatic logic pair_differs(input base_t a, input base_t b);
		base_t fa;
		base_t fb;
		fa = fold_base(a);
		fb = fold_base(b);
		return !is_blank(a) && !is_blank(b) && (fa != fb) && !is_masked(fa) && !is_masked(fb);
	endfunction

	// new site value after folding one sample base into it
	function automatic base_t merge_site(input base_t m, input base_t base);
		base_t r;
		r = m;
		if (m == UNSET_SITE) begin
			r = base;
		end else if (m != VARIANT_SITE) begin
			if (is_gap_or_n(m)) begin
				if (!is_gap_or_n(base)) begin
					r = base;
				end
			end else if ((m != base) && !is_gap_or_n(base)) begin
				r = VARIANT_SITE;
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/vssd_model_mem.sv
// site model store: one-port-write, one-port-read memory with registered read data
// runs a clearing pass to tab after reset; depends on vssd_pkg
module vssd_model_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output vssd_pkg::base_t      rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  vssd_pkg::base_t      wr_data,
	output logic                 busy
);
	import vssd_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	base_t         mem [DEPTH];
	base_t         rd_data_q;
	logic [AW-1:0] clr_addr_q;
	logic          busy_q;

	// clearing pass sweeps every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// write port shared by the clearing pass and read-modify-write traffic
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= UNSET_SITE;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held when no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// File: hw/rtl/variant_site_snp_distance.sv
// variant-site snp distance: one request per cycle once the site store is cleared, unless a held last compare stalls
// a last compare passes through stage 1 and then the output register before its distance shows
// the site store is read at acceptance and written back from stage 1 in the following cycle, with forwarding
// the single read-modify-write slot of the store takes one request a cycle when nothing stalls
// after reset the store is swept to tab, entry by entry; requests are stalled until done
// depends on vssd_pkg and vssd_model_mem
module variant_site_snp_distance #(
	parameter int SITES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  logic             mode,
	input  logic [15:0]      position,
	input  vssd_pkg::base_t  base_a,
	input  vssd_pkg::base_t  base_b,
	input  logic             last,
	output logic             dist_valid,
	input  logic             dist_stall,
	output vssd_pkg::count_t distance
);
	import vssd_pkg::*;

	localparam int AW = (SITES > 1) ? $clog2(SITES) : 1;

	logic          accept;
	logic          in_range;
	logic [AW-1:0] addr_in;

	logic          valid_s1;
	logic          mode_s1;
	logic          last_s1;
	logic          inrng_s1;
	logic [AW-1:0] addr_s1;
	base_t         base_a_s1;
	base_t         base_b_s1;
	logic          fwd_s1;
	base_t         fwd_data_s1;

	base_t         rd_data;
	logic          mem_busy;
	base_t         site_s1;
	logic          wr_en;
	base_t         wr_data;

	logic          hold_s1;
	logic          hit;
	logic          emit;
	count_t        count_q;
	count_t        count_inc;
	logic          dist_valid_q;
	count_t        dist_q;

	// request decode
	assign accept   = valid && !stall;
	assign in_range = 32'(position) < 32'(SITES);
	assign addr_in  = AW'(position);

	// output register full and stalled holds a last compare in stage 1
	assign hold_s1 = valid_s1 && (mode_s1 == MODE_COMPARE) && last_s1 &&
		dist_valid_q && dist_stall;
	assign stall   = mem_busy || hold_s1;

	vssd_model_mem #(
		.DEPTH (SITES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (addr_in),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	// site value seen by stage 1, with the previous write forwarded
	assign site_s1 = fwd_s1 ? fwd_data_s1 : rd_data;
	assign wr_en   = valid_s1 && (mode_s1 == MODE_MERGE) && inrng_s1;
	assign wr_data = merge_site(site_s1, base_a_s1);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold_s1) begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload and forwarding capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= mode;
			last_s1     <= last;
			inrng_s1    <= in_range;
			addr_s1     <= addr_in;
			base_a_s1   <= base_a;
			base_b_s1   <= base_b;
			fwd_s1      <= wr_en && (addr_s1 == addr_in);
			fwd_data_s1 <= wr_data;
		end
	end

	// compare hit and saturating increment
	assign hit = valid_s1 && (mode_s1 == MODE_COMPARE) && inrng_s1 &&
		(site_s1 == VARIANT_SITE) && pair_differs(base_a_s1, base_b_s1);
	assign count_inc = (hit && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;
	assign emit = valid_s1 && (mode_s1 == MODE_COMPARE) && last_s1 && !hold_s1;

	// running count, cleared when a distance is emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (valid_s1 && !hold_s1 && (mode_s1 == MODE_COMPARE)) begin
			count_q <= last_s1 ? '0 : count_inc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_valid_q <= 1'b0;
		end else if (emit) begin
			dist_valid_q <= 1'b1;
		end else if (!dist_stall) begin
			dist_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dist_q <= count_inc;
		end
	end

	assign dist_valid = dist_valid_q;
	assign distance   = dist_q;

	// no request is taken while the store is being cleared
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !accept)
		else $error("request accepted during clearing pass");

	// the clearing pass runs once
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!mem_busy |=> !mem_busy)
		else $error("clearing pass restarted");

	// a held last compare stays in stage 1
	a_hold_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		hold_s1 |=> valid_s1 && last_s1 && (mode_s1 == MODE_COMPARE))
		else $error("held compare lost from stage 1");

	// the count only grows until a distance is emitted
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && last_s1 && (mode_s1 == MODE_COMPARE)) |=> count_q >= $past(count_q))
		else $error("running count decreased without emit");

endmodule
